[rtl/rqbv_pkg.sv]
// Shared types, widths and constants for the shortest-arc quaternion pipeline.
package rqbv_pkg;

    localparam int COORD_W  = 16;
    localparam int OUT_W    = 16;
    localparam int OUT_FRAC = 14;

    localparam int DIFF_W   = COORD_W + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int DOT_W    = PROD_W + 2;
    localparam int CROSS_W  = PROD_W + 1;
    localparam int LEN_W    = PROD_W;
    localparam int HALF_W   = LEN_W / 2;
    localparam int PP_W     = LEN_W + (LEN_W - HALF_W);
    localparam int LL_W     = 2 * LEN_W;
    localparam int ROOT_W   = LEN_W;
    localparam int SUM_W    = ROOT_W + 1;
    localparam int CMAG_W   = CROSS_W - 1;
    localparam int SC_W     = 31;
    localparam int SHIFT_W  = $clog2(SUM_W - SC_W + 1);
    localparam int SQ_W     = 2 * SC_W;
    localparam int MSUM_W   = SQ_W + 2;
    localparam int QUO_W    = 2 * OUT_FRAC + 3;
    localparam int NRM_W    = (QUO_W + 1) / 2;
    localparam int UNIT_LAT = QUO_W + NRM_W + 2;

    localparam logic signed [OUT_W-1:0] Q_ONE = OUT_W'(2 ** OUT_FRAC);

    typedef struct packed {
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] first_z;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic signed [COORD_W-1:0] second_z;
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic signed [COORD_W-1:0] vertex_z;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] quat_w;
        logic signed [OUT_W-1:0] quat_x;
        logic signed [OUT_W-1:0] quat_y;
        logic signed [OUT_W-1:0] quat_z;
        logic                    opposite_flag;
        logic                    degenerate_flag;
    } t_out;

    typedef struct packed {
        logic opp;
        logic deg;
    } t_flag;

    typedef struct packed {
        logic signed [DOT_W-1:0]   d;
        logic signed [CROSS_W-1:0] cx;
        logic signed [CROSS_W-1:0] cy;
        logic signed [CROSS_W-1:0] cz;
        t_flag                     f;
    } t_side;

endpackage

[rtl/rqbv_unit.sv]
// Normalizer for one component: pipelined long division, square root and rounding.
module rqbv_unit (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [rqbv_pkg::SQ_W-1:0]           i_sq,
    input  logic                                i_neg,
    input  logic [rqbv_pkg::MSUM_W-1:0]         i_msum,
    output logic signed [rqbv_pkg::OUT_W-1:0]   o_part
);
    localparam int QW = rqbv_pkg::QUO_W;
    localparam int NW = rqbv_pkg::NRM_W;
    localparam int MW = rqbv_pkg::MSUM_W;

    logic [MW-1:0] r_drem [0:QW];
    logic [MW-1:0] r_dden [0:QW];
    logic [QW-1:0] r_dquo [0:QW];
    logic          r_dneg [0:QW];
    logic          r_dlsb;

    logic [NW-1:0]   r_srem  [1:NW];
    logic [NW-1:0]   r_sroot [1:NW];
    logic [2*NW-1:0] r_srad  [1:NW];
    logic            r_sneg  [1:NW];

    logic [NW:0]              w_rnd;
    logic signed [rqbv_pkg::OUT_W-1:0] r_part;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_drem[0] <= MW'(i_sq >> 1);
            r_dden[0] <= i_msum;
            r_dquo[0] <= '0;
            r_dneg[0] <= i_neg;
            r_dlsb    <= i_sq[0];
        end
    end

    for (genvar s = 0; s < QW; s++) begin : g_div
        logic          w_in;
        logic [MW:0]   w_cur;
        logic [MW:0]   w_dif;
        logic          w_ge;
        if (s == 0) begin : g_first
            assign w_in = r_dlsb;
        end else begin : g_next
            assign w_in = 1'b0;
        end
        assign w_cur = {r_drem[s], w_in};
        assign w_dif = w_cur - {1'b0, r_dden[s]};
        assign w_ge  = w_cur >= {1'b0, r_dden[s]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_drem[s+1] <= w_ge ? w_dif[MW-1:0] : w_cur[MW-1:0];
                r_dden[s+1] <= r_dden[s];
                r_dquo[s+1] <= {r_dquo[s][QW-2:0], w_ge};
                r_dneg[s+1] <= r_dneg[s];
            end
        end
    end

    for (genvar s = 0; s < NW; s++) begin : g_sqrt
        logic [NW-1:0]   w_rem;
        logic [NW-1:0]   w_root;
        logic [2*NW-1:0] w_rad;
        logic            w_neg;
        logic [NW+1:0]   w_cur;
        logic [NW+1:0]   w_trial;
        logic [NW+1:0]   w_dif;
        logic            w_ge;
        if (s == 0) begin : g_first
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_rad  = (2*NW)'(r_dquo[QW]);
            assign w_neg  = r_dneg[QW];
        end else begin : g_next
            assign w_rem  = r_srem[s];
            assign w_root = r_sroot[s];
            assign w_rad  = r_srad[s];
            assign w_neg  = r_sneg[s];
        end
        assign w_cur   = {w_rem, w_rad[2*NW-1 -: 2]};
        assign w_trial = {w_root, 2'b01};
        assign w_dif   = w_cur - w_trial;
        assign w_ge    = w_cur >= w_trial;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_srem[s+1]  <= w_ge ? w_dif[NW-1:0] : w_cur[NW-1:0];
                r_sroot[s+1] <= {w_root[NW-2:0], w_ge};
                r_srad[s+1]  <= w_rad << 2;
                r_sneg[s+1]  <= w_neg;
            end
        end
    end

    assign w_rnd = (NW+1)'(r_sroot[NW]) + (NW+1)'(1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_part <= r_sneg[NW] ? -rqbv_pkg::OUT_W'(w_rnd[NW:1])
                                 :  rqbv_pkg::OUT_W'(w_rnd[NW:1]);
        end
    end

    assign o_part = r_part;

endmodule

[rtl/rotation_quaternion_between_vectors.sv]
// Top level: shortest-arc unit quaternion between two vertex-relative vectors.
//
//   channel   valid     stall     payload
//   in        i_valid   o_stall   i_item  (rqbv_pkg::t_in)
//   out       o_valid   i_stall   o_item  (rqbv_pkg::t_out)
//
// One item per cycle while a stalled output does not hold the pipeline; an accepted item passes
// through the 34-step root of |a|^2|b|^2, the 31-step division and the 16-step root
// in each normalizer before it shows on o_valid.
// Synchronous active-low reset clears the valid bits, the input skid valid among them.
// A stalled output freezes the whole pipeline; the input skid register takes
// one more item so that o_stall comes from a flop.
module rotation_quaternion_between_vectors (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  rqbv_pkg::t_in    i_item,
    output logic             o_valid,
    input  logic             i_stall,
    output rqbv_pkg::t_out   o_item
);
    localparam int DIFF_W  = rqbv_pkg::DIFF_W;
    localparam int PROD_W  = rqbv_pkg::PROD_W;
    localparam int DOT_W   = rqbv_pkg::DOT_W;
    localparam int CROSS_W = rqbv_pkg::CROSS_W;
    localparam int LEN_W   = rqbv_pkg::LEN_W;
    localparam int HALF_W  = rqbv_pkg::HALF_W;
    localparam int PP_W    = rqbv_pkg::PP_W;
    localparam int LL_W    = rqbv_pkg::LL_W;
    localparam int KN      = rqbv_pkg::ROOT_W;
    localparam int SUM_W   = rqbv_pkg::SUM_W;
    localparam int CMAG_W  = rqbv_pkg::CMAG_W;
    localparam int SC_W    = rqbv_pkg::SC_W;
    localparam int SHIFT_W = rqbv_pkg::SHIFT_W;
    localparam int SQ_W    = rqbv_pkg::SQ_W;
    localparam int MSUM_W  = rqbv_pkg::MSUM_W;
    localparam int OUT_W   = rqbv_pkg::OUT_W;
    localparam int UL      = rqbv_pkg::UNIT_LAT;

    logic w_en;

    logic            r_skid_v;
    rqbv_pkg::t_in   r_skid;
    logic            w_src_v;
    rqbv_pkg::t_in   w_src;

    logic signed [DIFF_W-1:0] w_a [0:2];
    logic signed [DIFF_W-1:0] w_b [0:2];

    logic                     r_p1_v;
    logic signed [DIFF_W-1:0] r_p1_a [0:2];
    logic signed [DIFF_W-1:0] r_p1_b [0:2];

    logic                     r_p2_v;
    logic                     r_p2_deg;
    logic signed [PROD_W-1:0] r_p2_aa [0:2];
    logic signed [PROD_W-1:0] r_p2_bb [0:2];
    logic signed [PROD_W-1:0] r_p2_dt [0:2];
    logic signed [PROD_W-1:0] r_p2_cp [0:2];
    logic signed [PROD_W-1:0] r_p2_cm [0:2];

    rqbv_pkg::t_side w_p3_side;
    logic [LEN_W-1:0] w_la;
    logic [LEN_W-1:0] w_lb;

    logic              r_p3_v;
    rqbv_pkg::t_side   r_p3_side;
    logic [LEN_W-1:0]  r_p3_la;
    logic [LEN_W-1:0]  r_p3_lb;

    logic              r_p4_v;
    rqbv_pkg::t_side   r_p4_side;
    logic [PP_W-1:0]   r_p4_lo;
    logic [PP_W-1:0]   r_p4_hi;

    logic              r_k_v    [0:KN];
    rqbv_pkg::t_side   r_k_side [0:KN];
    logic [KN-1:0]     r_k_rem  [0:KN];
    logic [KN-1:0]     r_k_root [0:KN];
    logic [LL_W-1:0]   r_k_rad  [0:KN];

    logic signed [DOT_W:0] w_sk;
    logic [CMAG_W-1:0]     w_cm [1:3];
    logic                  w_cn [1:3];

    logic              r_pa_v;
    rqbv_pkg::t_flag   r_pa_f;
    logic [SUM_W-1:0]  r_pa_m   [0:3];
    logic              r_pa_neg [1:3];

    logic [SUM_W-1:0]   w_or;
    logic [SHIFT_W-1:0] w_sh;

    logic              r_pb_v;
    rqbv_pkg::t_flag   r_pb_f;
    logic [SC_W-1:0]   r_pb_m   [0:3];
    logic              r_pb_neg [1:3];

    logic              r_pc_v;
    rqbv_pkg::t_flag   r_pc_f;
    logic [SQ_W-1:0]   r_pc_sq  [0:3];
    logic              r_pc_neg [1:3];

    logic              r_pd_v;
    rqbv_pkg::t_flag   r_pd_f;
    logic [SQ_W-1:0]   r_pd_sq  [0:3];
    logic              r_pd_neg [0:3];
    logic [MSUM_W-1:0] r_pd_msum;

    logic              r_dly_v [0:UL-1];
    rqbv_pkg::t_flag   r_dly_f [0:UL-1];

    logic signed [OUT_W-1:0] w_part [0:3];
    rqbv_pkg::t_out          w_q;

    logic            r_o_v;
    rqbv_pkg::t_out  r_o_item;

    assign w_en    = !r_o_v || !i_stall;
    assign o_stall = r_skid_v;
    assign w_src_v = r_skid_v || i_valid;
    assign w_src   = r_skid_v ? r_skid : i_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (w_en) begin
            r_skid_v <= 1'b0;
        end else if (i_valid) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_en && !r_skid_v) begin
            r_skid <= i_item;
        end
    end

    assign w_a[0] = DIFF_W'(w_src.first_x)  - DIFF_W'(w_src.vertex_x);
    assign w_a[1] = DIFF_W'(w_src.first_y)  - DIFF_W'(w_src.vertex_y);
    assign w_a[2] = DIFF_W'(w_src.first_z)  - DIFF_W'(w_src.vertex_z);
    assign w_b[0] = DIFF_W'(w_src.second_x) - DIFF_W'(w_src.vertex_x);
    assign w_b[1] = DIFF_W'(w_src.second_y) - DIFF_W'(w_src.vertex_y);
    assign w_b[2] = DIFF_W'(w_src.second_z) - DIFF_W'(w_src.vertex_z);

    always_comb begin
        w_p3_side.d  = DOT_W'(r_p2_dt[0]) + DOT_W'(r_p2_dt[1]) + DOT_W'(r_p2_dt[2]);
        w_p3_side.cx = CROSS_W'(r_p2_cp[0]) - CROSS_W'(r_p2_cm[0]);
        w_p3_side.cy = CROSS_W'(r_p2_cp[1]) - CROSS_W'(r_p2_cm[1]);
        w_p3_side.cz = CROSS_W'(r_p2_cp[2]) - CROSS_W'(r_p2_cm[2]);
        w_p3_side.f.deg = r_p2_deg;
        w_p3_side.f.opp = (w_p3_side.cx == '0) && (w_p3_side.cy == '0)
                       && (w_p3_side.cz == '0) && w_p3_side.d[DOT_W-1];
        w_la = LEN_W'(r_p2_aa[0]) + LEN_W'(r_p2_aa[1]) + LEN_W'(r_p2_aa[2]);
        w_lb = LEN_W'(r_p2_bb[0]) + LEN_W'(r_p2_bb[1]) + LEN_W'(r_p2_bb[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
            r_p4_v <= 1'b0;
            r_k_v[0] <= 1'b0;
        end else if (w_en) begin
            r_p1_v   <= w_src_v;
            r_p2_v   <= r_p1_v;
            r_p3_v   <= r_p2_v;
            r_p4_v   <= r_p3_v;
            r_k_v[0] <= r_p4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_a <= w_a;
            r_p1_b <= w_b;

            for (int i = 0; i < 3; i++) begin
                r_p2_aa[i] <= r_p1_a[i] * r_p1_a[i];
                r_p2_bb[i] <= r_p1_b[i] * r_p1_b[i];
                r_p2_dt[i] <= r_p1_a[i] * r_p1_b[i];
            end
            r_p2_cp[0] <= r_p1_a[1] * r_p1_b[2];
            r_p2_cm[0] <= r_p1_a[2] * r_p1_b[1];
            r_p2_cp[1] <= r_p1_a[2] * r_p1_b[0];
            r_p2_cm[1] <= r_p1_a[0] * r_p1_b[2];
            r_p2_cp[2] <= r_p1_a[0] * r_p1_b[1];
            r_p2_cm[2] <= r_p1_a[1] * r_p1_b[0];
            r_p2_deg   <= ((r_p1_a[0] == '0) && (r_p1_a[1] == '0) && (r_p1_a[2] == '0))
                       || ((r_p1_b[0] == '0) && (r_p1_b[1] == '0) && (r_p1_b[2] == '0));

            r_p3_side <= w_p3_side;
            r_p3_la   <= w_la;
            r_p3_lb   <= w_lb;

            r_p4_side <= r_p3_side;
            r_p4_lo   <= PP_W'(r_p3_la) * PP_W'(r_p3_lb[HALF_W-1:0]);
            r_p4_hi   <= PP_W'(r_p3_la) * PP_W'(r_p3_lb[LEN_W-1:HALF_W]);

            r_k_side[0] <= r_p4_side;
            r_k_rem[0]  <= '0;
            r_k_root[0] <= '0;
            r_k_rad[0]  <= LL_W'(r_p4_lo) + (LL_W'(r_p4_hi) << HALF_W);
        end
    end

    for (genvar s = 0; s < KN; s++) begin : g_root
        logic [KN+1:0] w_cur;
        logic [KN+1:0] w_trial;
        logic [KN+1:0] w_dif;
        logic          w_ge;
        assign w_cur   = {r_k_rem[s], r_k_rad[s][LL_W-1 -: 2]};
        assign w_trial = {r_k_root[s], 2'b01};
        assign w_dif   = w_cur - w_trial;
        assign w_ge    = w_cur >= w_trial;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_k_v[s+1] <= 1'b0;
            end else if (w_en) begin
                r_k_v[s+1] <= r_k_v[s];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_k_side[s+1] <= r_k_side[s];
                r_k_rem[s+1]  <= w_ge ? w_dif[KN-1:0] : w_cur[KN-1:0];
                r_k_root[s+1] <= {r_k_root[s][KN-2:0], w_ge};
                r_k_rad[s+1]  <= r_k_rad[s] << 2;
            end
        end
    end

    assign w_sk = $signed({{(DOT_W+1-KN){1'b0}}, r_k_root[KN]})
                + (DOT_W+1)'(r_k_side[KN].d);

    always_comb begin
        w_cn[1] = r_k_side[KN].cx[CROSS_W-1];
        w_cn[2] = r_k_side[KN].cy[CROSS_W-1];
        w_cn[3] = r_k_side[KN].cz[CROSS_W-1];
        w_cm[1] = w_cn[1] ? CMAG_W'(-r_k_side[KN].cx) : CMAG_W'(r_k_side[KN].cx);
        w_cm[2] = w_cn[2] ? CMAG_W'(-r_k_side[KN].cy) : CMAG_W'(r_k_side[KN].cy);
        w_cm[3] = w_cn[3] ? CMAG_W'(-r_k_side[KN].cz) : CMAG_W'(r_k_side[KN].cz);
    end

    always_comb begin
        w_or = r_pa_m[0] | r_pa_m[1] | r_pa_m[2] | r_pa_m[3];
        w_sh = '0;
        for (int i = SC_W; i < SUM_W; i++) begin
            if (w_or[i]) begin
                w_sh = SHIFT_W'(i - SC_W + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pa_v <= 1'b0;
            r_pb_v <= 1'b0;
            r_pc_v <= 1'b0;
            r_pd_v <= 1'b0;
        end else if (w_en) begin
            r_pa_v <= r_k_v[KN];
            r_pb_v <= r_pa_v;
            r_pc_v <= r_pb_v;
            r_pd_v <= r_pc_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pa_f    <= r_k_side[KN].f;
            r_pa_m[0] <= w_sk[SUM_W-1:0];
            for (int i = 1; i < 4; i++) begin
                r_pa_m[i]   <= SUM_W'(w_cm[i]);
                r_pa_neg[i] <= w_cn[i];
            end

            r_pb_f <= r_pa_f;
            for (int i = 0; i < 4; i++) begin
                r_pb_m[i] <= SC_W'(r_pa_m[i] >> w_sh);
            end
            r_pb_neg <= r_pa_neg;

            r_pc_f <= r_pb_f;
            for (int i = 0; i < 4; i++) begin
                r_pc_sq[i] <= SQ_W'(r_pb_m[i]) * SQ_W'(r_pb_m[i]);
            end
            r_pc_neg <= r_pb_neg;

            r_pd_f      <= r_pc_f;
            r_pd_sq     <= r_pc_sq;
            r_pd_neg[0] <= 1'b0;
            for (int i = 1; i < 4; i++) begin
                r_pd_neg[i] <= r_pc_neg[i];
            end
            r_pd_msum <= MSUM_W'(r_pc_sq[0]) + MSUM_W'(r_pc_sq[1])
                       + MSUM_W'(r_pc_sq[2]) + MSUM_W'(r_pc_sq[3]);
        end
    end

    for (genvar i = 0; i < 4; i++) begin : g_unit
        rqbv_unit u_unit (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_sq   (r_pd_sq[i]),
            .i_neg  (r_pd_neg[i]),
            .i_msum (r_pd_msum),
            .o_part (w_part[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < UL; i++) begin
                r_dly_v[i] <= 1'b0;
            end
            r_o_v <= 1'b0;
        end else if (w_en) begin
            r_dly_v[0] <= r_pd_v;
            for (int i = 1; i < UL; i++) begin
                r_dly_v[i] <= r_dly_v[i-1];
            end
            r_o_v <= r_dly_v[UL-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dly_f[0] <= r_pd_f;
            for (int i = 1; i < UL; i++) begin
                r_dly_f[i] <= r_dly_f[i-1];
            end
            r_o_item <= w_q;
        end
    end

    always_comb begin
        w_q.quat_w          = w_part[0];
        w_q.quat_x          = w_part[1];
        w_q.quat_y          = w_part[2];
        w_q.quat_z          = w_part[3];
        w_q.opposite_flag   = 1'b0;
        w_q.degenerate_flag = 1'b0;
        if (r_dly_f[UL-1].deg) begin
            w_q.quat_w          = rqbv_pkg::Q_ONE;
            w_q.quat_x          = '0;
            w_q.quat_y          = '0;
            w_q.quat_z          = '0;
            w_q.degenerate_flag = 1'b1;
        end else if (r_dly_f[UL-1].opp) begin
            w_q.quat_w        = '0;
            w_q.quat_x        = '0;
            w_q.quat_y        = rqbv_pkg::Q_ONE;
            w_q.quat_z        = '0;
            w_q.opposite_flag = 1'b1;
        end
    end

    assign o_valid = r_o_v;
    assign o_item  = r_o_item;

endmodule
